// ----- rtl/core/wsfh_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the websocket frame header parser
package wsfh_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LenWidth    = 64;
   localparam int unsigned KeyWidth    = 32;
   localparam int unsigned OpcodeWidth = 4;
   localparam int unsigned CountWidth  = 4;

   localparam logic [ByteWidth-1:0]  FinBit       = 8'b1000_0000;
   localparam logic [ByteWidth-1:0]  OpcodeMask   = 8'b0000_1111;
   localparam logic [ByteWidth-1:0]  LenCodeMask  = 8'b0111_1111;
   localparam logic [6:0]            LenCode16    = 7'h7E;
   localparam logic [6:0]            LenCode64    = 7'h7F;
   localparam logic [CountWidth-1:0] ExtBytes16   = 4'd2;
   localparam logic [CountWidth-1:0] ExtBytes64   = 4'd8;
   localparam logic [CountWidth-1:0] MaskKeyBytes = 4'd4;

   typedef enum logic [2:0] {
      PH_B0   = 3'd0,
      PH_B1   = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   typedef struct packed {
      logic                   fin;
      logic [OpcodeWidth-1:0] opcode;
      logic                   masked;
      logic [KeyWidth-1:0]    mask_key;
      logic [LenWidth-1:0]    payload_length;
      logic [ByteWidth-1:0]   payload_byte;
      logic                   has_byte;
      logic                   last_of_frame;
   } result_type;

endpackage

// ----- rtl/core/wsfh_in_stage.sv -----
`timescale 1ns / 1ps
// input register stage for stream bytes
module wsfh_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wsfh_pkg::ByteWidth-1:0] req_data_byte,
   input  logic                          advance,
   output logic                          beat_valid,
   output logic [wsfh_pkg::ByteWidth-1:0] beat_byte
);
   import wsfh_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ByteWidth-1:0] byte_ff, byte_in;
   logic                 load;

   assign req_stall = valid_ff & ~advance;
   assign load      = ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = req_valid;
         byte_in  = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign beat_valid = valid_ff;
   assign beat_byte  = byte_ff;

endmodule

// ----- rtl/core/wsfh_parse.sv -----
`timescale 1ns / 1ps
// header parse state and per-byte decode logic
module wsfh_parse (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           consume,
   input  logic [wsfh_pkg::ByteWidth-1:0] beat_byte,
   output logic                           produce,
   output wsfh_pkg::result_type           result
);
   import wsfh_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    ext_long_ff, ext_long_in;
   logic                    fin_ff, fin_in;
   logic [OpcodeWidth-1:0]  opcode_ff, opcode_in;
   logic                    masked_ff, masked_in;
   logic [KeyWidth-1:0]     key_ff, key_in;
   logic [LenWidth-1:0]     len_ff, len_in;
   logic [LenWidth-1:0]     remain_ff, remain_in;
   logic [6:0]              code;
   logic [CountWidth-1:0]   count_inc;
   logic [CountWidth-1:0]   ext_need;
   logic                    start;
   logic                    emit;
   logic [ByteWidth-1:0]    emit_byte;
   logic                    emit_has;
   logic                    emit_last;

   assign code      = beat_byte[6:0] & LenCodeMask[6:0];
   assign count_inc = count_ff + 1'b1;
   assign ext_need  = ext_long_ff ? ExtBytes64 : ExtBytes16;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      ext_long_in = ext_long_ff;
      fin_in      = fin_ff;
      opcode_in   = opcode_ff;
      masked_in   = masked_ff;
      key_in      = key_ff;
      len_in      = len_ff;
      remain_in   = remain_ff;
      start       = 1'b0;
      emit        = 1'b0;
      emit_byte   = '0;
      emit_has    = 1'b0;
      emit_last   = 1'b0;
      unique case (phase_ff)
         PH_B1: begin
            masked_in = beat_byte[7];
            key_in    = '0;
            count_in  = '0;
            if (code == LenCode16) begin
               ext_long_in = 1'b0;
               len_in      = '0;
               phase_in    = PH_EXT;
            end else if (code == LenCode64) begin
               ext_long_in = 1'b1;
               len_in      = '0;
               phase_in    = PH_EXT;
            end else begin
               len_in = {{(LenWidth-7){1'b0}}, code};
               if (beat_byte[7]) begin
                  phase_in = PH_MASK;
               end else begin
                  start = 1'b1;
               end
            end
         end
         PH_EXT: begin
            len_in   = {len_ff[LenWidth-ByteWidth-1:0], beat_byte};
            count_in = count_inc;
            if (count_inc == ext_need) begin
               count_in = '0;
               if (masked_ff) begin
                  phase_in = PH_MASK;
               end else begin
                  start = 1'b1;
               end
            end
         end
         PH_MASK: begin
            key_in   = {key_ff[KeyWidth-ByteWidth-1:0], beat_byte};
            count_in = count_inc;
            if (count_inc == MaskKeyBytes) begin
               start = 1'b1;
            end
         end
         PH_DATA: begin
            remain_in = remain_ff - 1'b1;
            emit      = 1'b1;
            emit_byte = beat_byte;
            emit_has  = 1'b1;
            if (remain_in == '0) begin
               emit_last = 1'b1;
               phase_in  = PH_B0;
            end
         end
         default: begin
            fin_in    = beat_byte[7];
            opcode_in = beat_byte[OpcodeWidth-1:0] & OpcodeMask[OpcodeWidth-1:0];
            phase_in  = PH_B1;
         end
      endcase
      if (start) begin
         count_in  = '0;
         remain_in = len_in;
         if (len_in == '0) begin
            phase_in  = PH_B0;
            emit      = 1'b1;
            emit_last = 1'b1;
         end else begin
            phase_in = PH_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_B0;
         count_ff    <= '0;
         ext_long_ff <= 1'b0;
         fin_ff      <= 1'b0;
         opcode_ff   <= '0;
         masked_ff   <= 1'b0;
         key_ff      <= '0;
         len_ff      <= '0;
         remain_ff   <= '0;
      end else if (consume) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         ext_long_ff <= ext_long_in;
         fin_ff      <= fin_in;
         opcode_ff   <= opcode_in;
         masked_ff   <= masked_in;
         key_ff      <= key_in;
         len_ff      <= len_in;
         remain_ff   <= remain_in;
      end
   end

   assign produce               = consume & emit;
   assign result.fin            = fin_in;
   assign result.opcode         = opcode_in;
   assign result.masked         = masked_in;
   assign result.mask_key       = key_in;
   assign result.payload_length = len_in;
   assign result.payload_byte   = emit_byte;
   assign result.has_byte       = emit_has;
   assign result.last_of_frame  = emit_last;

endmodule

// ----- rtl/core/wsfh_out_stage.sv -----
`timescale 1ns / 1ps
// result register stage
module wsfh_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 produce,
   input  wsfh_pkg::result_type result,
   input  logic                 rsp_stall,
   output logic                 advance,
   output logic                 rsp_valid,
   output wsfh_pkg::result_type rsp_result
);
   import wsfh_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign advance = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = produce;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

endmodule

// ----- rtl/core/websocket_frame_header_parser_top.sv -----
`timescale 1ns / 1ps
// websocket frame header parser top level
//
// req channel: one stream byte per beat on req_data_byte, valid/stall handshake.
// rsp channel: zero or one result per byte; header bytes give none, each payload
// byte gives one tagged with fin, opcode, mask bit, mask key and payload length,
// and a frame with an empty payload gives one marker with has_byte low.
// last_of_frame flags the final result of each frame; parsing then restarts
// at the first header byte of the next frame.
// a byte accepted into the input register is decoded combinationally, and its result
// is captured in the result register, which drives the rsp channel.
// throughput: one byte per cycle while rsp_stall is low, set by the single input
// register and the single result register with one decode step between them.
// reset clears the parse state to the first header byte and empties both stages.
// when rsp_stall is high with a result waiting, the result holds, one more byte
// may sit in the input register, and req_stall then rises until the result moves.
module websocket_frame_header_parser_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [wsfh_pkg::ByteWidth-1:0]   req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_fin,
   output logic [wsfh_pkg::OpcodeWidth-1:0] rsp_opcode,
   output logic                            rsp_masked,
   output logic [wsfh_pkg::KeyWidth-1:0]    rsp_mask_key,
   output logic [wsfh_pkg::LenWidth-1:0]    rsp_payload_length,
   output logic [wsfh_pkg::ByteWidth-1:0]   rsp_payload_byte,
   output logic                            rsp_has_byte,
   output logic                            rsp_last_of_frame
);
   import wsfh_pkg::*;

   logic                 advance;
   logic                 beat_valid;
   logic [ByteWidth-1:0] beat_byte;
   logic                 consume;
   logic                 produce;
   result_type           result;
   result_type           rsp_result;

   assign consume = beat_valid & advance;

   wsfh_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .beat_valid    (beat_valid),
      .beat_byte     (beat_byte)
   );

   wsfh_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .consume   (consume),
      .beat_byte (beat_byte),
      .produce   (produce),
      .result    (result)
   );

   wsfh_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .produce    (produce),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_fin            = rsp_result.fin;
   assign rsp_opcode         = rsp_result.opcode;
   assign rsp_masked         = rsp_result.masked;
   assign rsp_mask_key       = rsp_result.mask_key;
   assign rsp_payload_length = rsp_result.payload_length;
   assign rsp_payload_byte   = rsp_result.payload_byte;
   assign rsp_has_byte       = rsp_result.has_byte;
   assign rsp_last_of_frame  = rsp_result.last_of_frame;

endmodule

// ----- rtl/core/wsfh_checker.sv -----
`timescale 1ns / 1ps
// port-level checker for the websocket frame header parser, with its bind
module wsfh_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_masked,
   input logic [wsfh_pkg::KeyWidth-1:0]    rsp_mask_key,
   input logic [wsfh_pkg::LenWidth-1:0]    rsp_payload_length,
   input logic [wsfh_pkg::ByteWidth-1:0]   rsp_payload_byte,
   input logic                            rsp_has_byte,
   input logic                            rsp_last_of_frame
);
   import wsfh_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_last_of_frame))
      else $error("stalled result beat changed");

   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_last_of_frame && rsp_payload_byte == '0
         && rsp_payload_length == '0)
      else $error("empty frame marker malformed");

   a_unmasked_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_masked |-> rsp_mask_key == '0)
      else $error("mask key set on unmasked frame");

endmodule

bind websocket_frame_header_parser_top wsfh_checker u_wsfh_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_masked         (rsp_masked),
   .rsp_mask_key       (rsp_mask_key),
   .rsp_payload_length (rsp_payload_length),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_has_byte       (rsp_has_byte),
   .rsp_last_of_frame  (rsp_last_of_frame)
);
